// ----- rtl/core/mfwm_pkg.sv -----
// ----------------------------------------------------------------------------
// mfwm_pkg
// Shared types, constants and helpers for the multi-filter wildcard matcher.
// ----------------------------------------------------------------------------
package mfwm_pkg;

   // Default geometry of the filter table.
   localparam int NUM_FILTERS_DEF  = 10;
   localparam int FILTER_BYTES_DEF = 15;

   // Pattern and folding characters.
   localparam logic [7:0] CHAR_STAR   = 8'h2A;
   localparam logic [7:0] CHAR_QUEST  = 8'h3F;
   localparam logic [7:0] CHAR_DOT    = 8'h2E;
   localparam logic [7:0] CHAR_LC_A   = 8'h61;
   localparam logic [7:0] CHAR_LC_Z   = 8'h7A;
   localparam logic [7:0] CASE_OFFSET = 8'd32;
   localparam logic [7:0] CHAR_NUL    = 8'h00;

   // Register map.
   localparam logic REG_IGNORE_CASE = 1'b0;

   // What a request transaction carries.
   typedef enum logic {
      KIND_TABLE = 1'b0,
      KIND_NAME  = 1'b1
   } kind_type;

   typedef struct packed {
      kind_type   kind;
      logic [3:0] filter_slot;
      logic [3:0] filter_offset;
      logic [7:0] byte_value;
      logic       last_byte;
   } item_type;

   // Match summary handed from cell to cell along with each item.
   typedef struct packed {
      logic stop;
      logic any;
   } carry_type;

   // Upper-case a lower-case letter when case is ignored.
   function automatic logic [7:0] fold(input logic [7:0] c, input logic ic);
      logic [7:0] r;
      r = c;
      if (ic && c >= CHAR_LC_A && c <= CHAR_LC_Z) begin
         r = c - CASE_OFFSET;
      end
      return r;
   endfunction

endpackage

// ----- rtl/core/mfwm_cell.sv -----
// ----------------------------------------------------------------------------
// mfwm_cell
// One filter of the chain: holds its pattern bytes and active position set,
// advances the set on each name byte and passes the item to the next cell.
// ----------------------------------------------------------------------------
module mfwm_cell
   import mfwm_pkg::*;
#(
   parameter int CELL_INDEX   = 0,
   parameter int NUM_FILTERS  = NUM_FILTERS_DEF,
   parameter int FILTER_BYTES = FILTER_BYTES_DEF
) (
   input  logic      clock,
   input  logic      reset,
   input  logic      en,
   input  logic      ignore_case,
   input  logic      in_valid,
   input  item_type  in_item,
   input  carry_type in_carry,
   output logic      out_valid,
   output item_type  out_item,
   output carry_type out_carry
);

   localparam int NPOS = FILTER_BYTES + 1;

   logic [7:0]              tab_ff [FILTER_BYTES];
   logic [7:0]              tab_in [FILTER_BYTES];
   logic [NPOS-1:0]         act_ff, act_in;
   logic                    fresh_ff, fresh_in;
   logic                    valid_ff;
   item_type                item_ff;
   carry_type               carry_ff, carry_in;

   logic [FILTER_BYTES-1:0] nz, live, star, quest, eq, fire, stay;
   logic [NPOS-1:0]         rst_set, cur, raw, nxt, endp;
   logic                    accept;
   logic                    take, wr_ok, wr_mine;

   // Pattern byte classification and the live prefix of the filter.
   always_comb begin
      for (int p = 0; p < FILTER_BYTES; p++) begin
         nz[p]    = (tab_ff[p] != CHAR_NUL);
         star[p]  = (tab_ff[p] == CHAR_STAR);
         quest[p] = (tab_ff[p] == CHAR_QUEST);
         eq[p]    = (fold(tab_ff[p], ignore_case) == fold(in_item.byte_value, ignore_case));
      end
      live[0] = nz[0];
      for (int p = 1; p < FILTER_BYTES; p++) begin
         live[p] = live[p-1] & nz[p];
      end
   end

   // Start set: position zero plus every position reached across leading stars.
   always_comb begin
      rst_set    = '0;
      rst_set[0] = 1'b1;
      for (int p = 0; p < FILTER_BYTES; p++) begin
         rst_set[p+1] = rst_set[p] & live[p] & star[p];
      end
   end

   // Advance the active set by one name byte, then close over stars.
   always_comb begin
      cur = fresh_ff ? rst_set : act_ff;
      for (int p = 0; p < FILTER_BYTES; p++) begin
         stay[p] = cur[p] & live[p] & star[p];
         fire[p] = cur[p] & live[p] & ~star[p] & (quest[p] | eq[p]);
      end
      raw[0] = stay[0];
      for (int p = 1; p < FILTER_BYTES; p++) begin
         raw[p] = stay[p] | fire[p-1];
      end
      raw[FILTER_BYTES] = fire[FILTER_BYTES-1];
      nxt[0] = raw[0];
      for (int p = 0; p < FILTER_BYTES; p++) begin
         nxt[p+1] = raw[p+1] | (nxt[p] & live[p] & star[p]);
      end
   end

   // The filter accepts when the position just past its last byte is active.
   always_comb begin
      endp[0] = ~live[0];
      for (int p = 1; p < FILTER_BYTES; p++) begin
         endp[p] = live[p-1] & ~live[p];
      end
      endp[FILTER_BYTES] = live[FILTER_BYTES-1];
      accept = |(nxt & endp);
   end

   // Table writes: any in-range write restarts every cell, only one stores.
   always_comb begin
      take    = en & in_valid;
      wr_ok   = (in_item.kind == KIND_TABLE) &&
                (32'(in_item.filter_slot) < NUM_FILTERS) &&
                (32'(in_item.filter_offset) < FILTER_BYTES);
      wr_mine = take && wr_ok && (32'(in_item.filter_slot) == CELL_INDEX);
      for (int p = 0; p < FILTER_BYTES; p++) begin
         tab_in[p] = (wr_mine && (32'(in_item.filter_offset) == p)) ?
                     in_item.byte_value : tab_ff[p];
      end
   end

   // Next active set.
   always_comb begin
      act_in   = act_ff;
      fresh_in = fresh_ff;
      if (take) begin
         if (in_item.kind == KIND_TABLE) begin
            if (wr_ok) begin
               fresh_in = 1'b1;
            end
         end else if (in_item.last_byte) begin
            fresh_in = 1'b1;
         end else begin
            fresh_in = 1'b0;
            act_in   = nxt;
         end
      end
   end

   // Scanning stops at the first empty filter.
   always_comb begin
      carry_in.stop = in_carry.stop | ~nz[0];
      carry_in.any  = in_carry.any | (~carry_in.stop & accept);
   end

   // Filter bytes: filter zero comes up holding "*.*".
   always_ff @(posedge clock) begin
      for (int p = 0; p < FILTER_BYTES; p++) begin
         if (reset) begin
            if (CELL_INDEX == 0 && p == 0) begin
               tab_ff[p] <= CHAR_STAR;
            end else if (CELL_INDEX == 0 && p == 1) begin
               tab_ff[p] <= CHAR_DOT;
            end else if (CELL_INDEX == 0 && p == 2) begin
               tab_ff[p] <= CHAR_STAR;
            end else begin
               tab_ff[p] <= CHAR_NUL;
            end
         end else begin
            tab_ff[p] <= tab_in[p];
         end
      end
   end

   // Active set and restart flag.
   always_ff @(posedge clock) begin
      if (reset) begin
         fresh_ff <= 1'b1;
      end else begin
         fresh_ff <= fresh_in;
      end
      act_ff <= act_in;
   end

   // Stage register toward the next cell.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
      if (en) begin
         item_ff  <= in_item;
         carry_ff <= carry_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_item  = item_ff;
   assign out_carry = carry_ff;

endmodule

// ----- rtl/core/multi_filter_wildcard_match_core.sv -----
// ----------------------------------------------------------------------------
// multi_filter_wildcard_match_core
// Wildcard name matcher over a table of filters, one filter per chain cell.
// ----------------------------------------------------------------------------
// The block takes one transaction per clock while req_tready is high: either a
// filter table byte (tuser = 0) or a name byte (tuser = 1, tlast on the final
// byte). Each transaction walks a chain of NUM_FILTERS cells, and a name's final
// byte yields one result transaction once it has passed the stage register of
// every cell and then the response register; the rate stays at one transaction
// per cycle while no result is stalled. A result that is not taken stalls the
// chain only once the next final name byte reaches the end of it. Filter zero
// holds "*.*" after reset, and the user must write ignore_case (register 0 at
// address 0) only while the block is idle; the block itself does not enforce it.
module multi_filter_wildcard_match_core
   import mfwm_pkg::*;
#(
   parameter int NUM_FILTERS  = NUM_FILTERS_DEF,
   parameter int FILTER_BYTES = FILTER_BYTES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   // Request stream.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // filter_slot[3:0], filter_offset[7:4], byte_value[15:8]
   input  logic        req_tuser,   // kind[0]
   input  logic        req_tlast,   // last_byte
   // Response stream.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // matched[0], zero fill [7:1]
   // Register port.
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   logic      ic_ff, ic_in;
   logic      rsp_tvalid_ff, rsp_tvalid_in;
   logic      matched_ff, matched_in;
   logic      en, res_ready, csr_wr;

   logic      ch_valid [NUM_FILTERS+1];
   item_type  ch_item  [NUM_FILTERS+1];
   carry_type ch_carry [NUM_FILTERS+1];

   // Register port: writes complete in the access phase.
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_comb begin
      ic_in = ic_ff;
      if (csr_wr && csr_paddr[2] == REG_IGNORE_CASE) begin
         ic_in = csr_pwdata[0];
      end
      csr_prdata = (csr_paddr[2] == REG_IGNORE_CASE) ? {31'b0, ic_ff} : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ic_ff <= 1'b0;
      end else begin
         ic_ff <= ic_in;
      end
   end

   // Chain head takes the request fields.
   always_comb begin
      ch_valid[0]               = req_tvalid;
      ch_item[0].kind           = kind_type'(req_tuser);
      ch_item[0].filter_slot    = req_tdata[3:0];
      ch_item[0].filter_offset  = req_tdata[7:4];
      ch_item[0].byte_value     = req_tdata[15:8];
      ch_item[0].last_byte      = req_tlast;
      ch_carry[0].stop          = 1'b0;
      ch_carry[0].any           = 1'b0;
   end

   // One cell per filter.
   for (genvar i = 0; i < NUM_FILTERS; i++) begin : g_cell
      mfwm_cell #(
         .CELL_INDEX   (i),
         .NUM_FILTERS  (NUM_FILTERS),
         .FILTER_BYTES (FILTER_BYTES)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .en          (en),
         .ignore_case (ic_ff),
         .in_valid    (ch_valid[i]),
         .in_item     (ch_item[i]),
         .in_carry    (ch_carry[i]),
         .out_valid   (ch_valid[i+1]),
         .out_item    (ch_item[i+1]),
         .out_carry   (ch_carry[i+1])
      );
   end

   // The chain stalls only when a new result meets an untaken one.
   always_comb begin
      res_ready  = ch_valid[NUM_FILTERS] &&
                   (ch_item[NUM_FILTERS].kind == KIND_NAME) &&
                   ch_item[NUM_FILTERS].last_byte;
      en         = ~(res_ready & rsp_tvalid_ff & ~rsp_tready);
      req_tready = en;
   end

   // Response register.
   always_comb begin
      rsp_tvalid_in = rsp_tvalid_ff & ~rsp_tready;
      matched_in    = matched_ff;
      if (en && res_ready) begin
         rsp_tvalid_in = 1'b1;
         matched_in    = ch_carry[NUM_FILTERS].any;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else begin
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
      matched_ff <= matched_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {7'b0, matched_ff};

   // A response only appears when a final name byte leaves the chain.
   a_rsp_source : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(res_ready && en))
      else $error("response raised without a final name byte at the chain end");

   // Back-pressure on requests comes only from an untaken response.
   a_stall_cause : assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (rsp_tvalid && !rsp_tready && res_ready))
      else $error("request stalled without a blocked response");

   // A register write lands in the case-fold flag.
   a_csr_write : assert property (@(posedge clock) disable iff (reset)
      (csr_wr && csr_paddr[2] == REG_IGNORE_CASE) |=> (ic_ff == $past(csr_pwdata[0])))
      else $error("ignore_case not updated by register write");

endmodule

// ----- tb/sv/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the multi-filter wildcard name matcher.
// ----------------------------------------------------------------------------
// A short table of hand-picked transactions runs first: the reset filter, an
// emptied first slot, '?' and '*' patterns, a table write in the middle of a
// name, out-of-range writes and the ignored fields. Randomized phases follow.
// They program filters, derive names from them, add noise writes and random
// names, and switch ignore_case between phases. Every accepted request goes
// through a local matcher that tracks the filter table and the live pattern
// positions, and every response transaction is checked against it in order.
// ----------------------------------------------------------------------------
module tb_top
   import mfwm_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int NF = NUM_FILTERS_DEF;
   localparam int FB = FILTER_BYTES_DEF;

   // A response passes the stage register of each filter cell and then the response register.
   localparam int DRAIN_CYCLES = 2 * NF + 8;
   localparam int PHASE_ITEMS  = 450;
   localparam int RUN_LIMIT_NS = 2_000_000;

   // Per phase: sender idle percentage, receiver stall percentage, case mode.
   localparam int SEND_IDLE [4]   = '{0, 81, 0, 34};
   localparam int TAKE_STALL [4]  = '{0, 0, 81, 34};
   localparam logic CASE_MODE [4] = '{1'b1, 1'b0, 1'b1, 1'b0};

   // How the expected match of a directed row is found.
   localparam logic [1:0] WANT_MISS      = 2'd0;
   localparam logic [1:0] WANT_HIT       = 2'd1;
   localparam logic [1:0] WANT_PREDICTED = 2'd2;

   typedef struct packed {
      kind_type   kind;
      logic [3:0] slot;
      logic [3:0] offset;
      logic [7:0] value;
      logic       last;
      logic [1:0] want;
   } dir_row_type;

   // Directed transactions, in order.
   localparam dir_row_type DIRECTED_ROWS [23] = '{
      '{KIND_NAME,  4'd0,  4'd0,  ".",   1'b1, WANT_HIT},       // reset filter *.*
      '{KIND_NAME,  4'd0,  4'd0,  "a",   1'b0, WANT_PREDICTED},
      '{KIND_NAME,  4'd0,  4'd0,  "b",   1'b1, WANT_MISS},      // no dot in name
      '{KIND_TABLE, 4'd15, 4'd15, 8'h00, 1'b1, WANT_PREDICTED}, // out of range
      '{KIND_TABLE, 4'd9,  4'd14, 8'hFF, 1'b0, WANT_PREDICTED},
      '{KIND_TABLE, 4'd0,  4'd0,  8'h00, 1'b0, WANT_PREDICTED}, // empty slot 0
      '{KIND_NAME,  4'd0,  4'd0,  8'hFF, 1'b1, WANT_MISS},
      '{KIND_TABLE, 4'd0,  4'd0,  "?",   1'b0, WANT_PREDICTED}, // now ?.*
      '{KIND_NAME,  4'd15, 4'd15, "x",   1'b0, WANT_PREDICTED},
      '{KIND_NAME,  4'd0,  4'd0,  ".",   1'b1, WANT_HIT},
      '{KIND_NAME,  4'd0,  4'd0,  ".",   1'b1, WANT_MISS},      // ? needs a byte
      '{KIND_TABLE, 4'd1,  4'd0,  "A",   1'b0, WANT_PREDICTED},
      '{KIND_NAME,  4'd0,  4'd0,  "a",   1'b1, WANT_MISS},      // case matters
      '{KIND_NAME,  4'd0,  4'd0,  "Q",   1'b0, WANT_PREDICTED},
      '{KIND_TABLE, 4'd5,  4'd3,  8'h00, 1'b0, WANT_PREDICTED}, // restarts the name
      '{KIND_NAME,  4'd0,  4'd0,  "A",   1'b1, WANT_HIT},
      '{KIND_TABLE, 4'd3,  4'd0,  "A",   1'b1, WANT_PREDICTED},
      '{KIND_TABLE, 4'd2,  4'd0,  "*",   1'b0, WANT_PREDICTED},
      '{KIND_NAME,  4'd0,  4'd0,  8'h00, 1'b1, WANT_HIT},       // lone star
      '{KIND_TABLE, 4'd2,  4'd0,  8'h00, 1'b0, WANT_PREDICTED},
      '{KIND_TABLE, 4'd10, 4'd0,  "*",   1'b0, WANT_PREDICTED}, // slot out of range
      '{KIND_NAME,  4'd0,  4'd0,  "z",   1'b0, WANT_PREDICTED},
      '{KIND_NAME,  4'd0,  4'd0,  ".",   1'b1, WANT_PREDICTED}
   };

   logic        clock;
   logic        reset       = 1'b1;
   logic        req_tvalid  = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata   = '0;   // filter_slot[3:0], filter_offset[7:4], byte_value[15:8]
   logic        req_tuser   = 1'b0; // kind[0]
   logic        req_tlast   = 1'b0; // last_byte
   logic        rsp_tvalid;
   logic        rsp_tready  = 1'b0;
   logic [7:0]  rsp_tdata;          // matched[0], zero fill [7:1]
   logic        csr_psel    = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite  = 1'b0;
   logic [2:0]  csr_paddr   = '0;
   logic [31:0] csr_pwdata  = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   // Local copy of the matcher state.
   logic [7:0]  flt_bytes [NF][FB];
   logic [FB:0] live_pos [NF];
   logic        case_blind;

   logic        pending_matches [$];
   logic [7:0]  name_buf [$];
   int          mismatches = 0;
   int          accepted   = 0;
   int          send_idle  = 0;
   int          take_stall = 0;

   multi_filter_wildcard_match_core uut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // A filter ends at its first zero byte.
   function automatic int pattern_len(int f);
      int n;
      n = 0;
      while (n < FB && flt_bytes[f][n] != CHAR_NUL) n++;
      return n;
   endfunction

   // Number of filters scanned before the first empty slot.
   function automatic int scanned_count();
      int n;
      n = 0;
      while (n < NF && flt_bytes[n][0] != CHAR_NUL) n++;
      return n;
   endfunction

   function automatic logic [7:0] upcase(logic [7:0] c);
      if (case_blind && c >= CHAR_LC_A && c <= CHAR_LC_Z) begin
         return c - CASE_OFFSET;
      end
      return c;
   endfunction

   // Extend a position set across every star it reaches.
   function automatic logic [FB:0] star_close(int f, logic [FB:0] set);
      int len;
      logic [FB:0] s;
      len = pattern_len(f);
      s = set;
      for (int p = 0; p < len; p++) begin
         if (s[p] && flt_bytes[f][p] == CHAR_STAR) begin
            s[p + 1] = 1'b1;
         end
      end
      return s;
   endfunction

   function automatic void restart_positions();
      for (int f = 0; f < NF; f++) begin
         live_pos[f] = star_close(f, {{FB{1'b0}}, 1'b1});
      end
   endfunction

   // Apply one request; returns 1 when it produces a response.
   function automatic bit apply_item(input item_type it, output logic hit);
      logic [FB:0] nxt;
      logic [7:0]  pc;
      int          len;
      hit = 1'b0;
      if (it.kind == KIND_TABLE) begin
         if (it.filter_slot < NF && it.filter_offset < FB) begin
            flt_bytes[it.filter_slot][it.filter_offset] = it.byte_value;
            restart_positions();
         end
         return 1'b0;
      end
      for (int f = 0; f < NF; f++) begin
         len = pattern_len(f);
         nxt = '0;
         for (int p = 0; p < len; p++) begin
            pc = flt_bytes[f][p];
            if (live_pos[f][p]) begin
               if (pc == CHAR_STAR) begin
                  nxt[p] = 1'b1;
               end else if (pc == CHAR_QUEST || upcase(pc) == upcase(it.byte_value)) begin
                  nxt[p + 1] = 1'b1;
               end
            end
         end
         live_pos[f] = star_close(f, nxt);
      end
      if (!it.last_byte) begin
         return 1'b0;
      end
      for (int f = 0; f < scanned_count(); f++) begin
         if (live_pos[f][pattern_len(f)]) hit = 1'b1;
      end
      restart_positions();
      return 1'b1;
   endfunction

   function automatic item_type make_item(kind_type k, logic [3:0] s, logic [3:0] o,
                                          logic [7:0] v, logic l);
      item_type it;
      it.kind          = k;
      it.filter_slot   = s;
      it.filter_offset = o;
      it.byte_value    = v;
      it.last_byte     = l;
      return it;
   endfunction

   // Letters around the fold range, the dot, and any byte at all.
   function automatic logic [7:0] name_char();
      logic [7:0] c;
      case ($urandom_range(7))
         0: c = CHAR_LC_A;
         1: c = CHAR_LC_A + 8'd1;
         2: c = CHAR_LC_A - CASE_OFFSET;
         3: c = CHAR_LC_Z - CASE_OFFSET;
         4: c = CHAR_DOT;
         5: c = CHAR_LC_Z;
         default: c = 8'($urandom_range(255));
      endcase
      return c;
   endfunction

   function automatic logic [7:0] pattern_char();
      int r;
      logic [7:0] c;
      r = $urandom_range(99);
      if (r < 20) c = CHAR_STAR;
      else if (r < 35) c = CHAR_QUEST;
      else c = name_char();
      if (c == CHAR_NUL) c = CHAR_DOT;
      return c;
   endfunction

   // Present one request transaction and record what it should produce.
   task automatic send_item(input item_type it, input logic [1:0] want);
      logic hit;
      bit   has;
      while ($urandom_range(99) < send_idle) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {it.byte_value, it.filter_offset, it.filter_slot};
      req_tuser  <= it.kind;
      req_tlast  <= it.last_byte;
      do @(posedge clock); while (!req_tready);
      has = apply_item(it, hit);
      if (has) pending_matches.push_back(want == WANT_PREDICTED ? hit : want[0]);
      if (it.kind == KIND_NAME || (it.filter_slot < NF && it.filter_offset < FB)) accepted++;
   endtask

   // Stream the name in name_buf, now and then with a table write inside it.
   task automatic send_name();
      int n;
      n = name_buf.size();
      for (int i = 0; i < n; i++) begin
         if (i > 0 && $urandom_range(99) < 3) begin
            send_item(make_item(KIND_TABLE, 4'($urandom_range(NF - 1)),
                                4'($urandom_range(FB - 1)), pattern_char(), 1'b0),
                      WANT_PREDICTED);
         end
         send_item(make_item(KIND_NAME, 4'($urandom_range(15)), 4'($urandom_range(15)),
                             name_buf[i], i == n - 1), WANT_PREDICTED);
      end
      name_buf.delete();
   endtask

   // Write a whole filter, mostly short, sometimes filling every byte.
   task automatic program_filter(int f);
      int len;
      len = ($urandom_range(9) == 0) ? FB : $urandom_range(1, 5);
      for (int p = 0; p < len; p++) begin
         send_item(make_item(KIND_TABLE, 4'(f), 4'(p), pattern_char(),
                             1'($urandom_range(1))), WANT_PREDICTED);
      end
      if (len < FB) begin
         send_item(make_item(KIND_TABLE, 4'(f), 4'(len), CHAR_NUL, 1'($urandom_range(1))),
                   WANT_PREDICTED);
      end
   endtask

   // Build a name that a filter should match, with the odd corruption.
   task automatic send_from_filter(int f);
      int len;
      logic [7:0] c;
      len = pattern_len(f);
      for (int p = 0; p < len; p++) begin
         c = flt_bytes[f][p];
         if (c == CHAR_STAR) begin
            repeat ($urandom_range(2)) name_buf.push_back(name_char());
         end else if (c == CHAR_QUEST) begin
            name_buf.push_back(name_char());
         end else begin
            if (c >= CHAR_LC_A && c <= CHAR_LC_Z && $urandom_range(2) == 0) begin
               c = c - CASE_OFFSET;
            end else if (c >= CHAR_LC_A - CASE_OFFSET && c <= CHAR_LC_Z - CASE_OFFSET &&
                         $urandom_range(2) == 0) begin
               c = c + CASE_OFFSET;
            end
            name_buf.push_back(c);
         end
      end
      if (name_buf.size() > 0 && $urandom_range(9) == 0) begin
         name_buf[$urandom_range(name_buf.size() - 1)] = name_char();
      end
      if (name_buf.size() == 0) name_buf.push_back(name_char());
      send_name();
   endtask

   // Wait until every response has arrived and the chain has emptied.
   task automatic drain();
      req_tvalid <= 1'b0;
      while (pending_matches.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_ignore_case(input logic v);
      drain();
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr   <= {REG_IGNORE_CASE, 2'b00};
      csr_pwdata  <= {31'd0, v};
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      case_blind = v;
   endtask

   // Mostly names derived from live filters, plus rewrites, noise and junk names.
   task automatic run_phase(int quota);
      int stop_at;
      int r;
      int live;
      stop_at = accepted + quota;
      while (accepted < stop_at) begin
         r = $urandom_range(99);
         live = scanned_count();
         if (r < 12) begin
            program_filter($urandom_range(NF - 1));
         end else if (r < 17) begin
            send_item(make_item(KIND_TABLE, 4'($urandom_range(15)), 4'($urandom_range(15)),
                                8'($urandom_range(255)), 1'($urandom_range(1))),
                      WANT_PREDICTED);
         end else if (r < 20) begin
            send_item(make_item(KIND_TABLE, 4'($urandom_range(NF - 1)), 4'd0, CHAR_NUL,
                                1'($urandom_range(1))), WANT_PREDICTED);
         end else if (r < 75 && live > 0) begin
            send_from_filter($urandom_range(live - 1));
         end else begin
            repeat ($urandom_range(1, ($urandom_range(7) == 0) ? 16 : 6)) begin
               name_buf.push_back(name_char());
            end
            send_name();
         end
      end
   endtask

   // Receiver side: take responses or stall at the phase's rate.
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= take_stall);
   end

   // Compare each response transaction with the oldest expected match.
   always @(posedge clock) begin : check_results
      logic want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_matches.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("%0t: response with none expected, matched=%0b", $realtime, rsp_tdata[0]);
            end
         end else begin
            want = pending_matches.pop_front();
            if (rsp_tdata[0] !== want) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("%0t: matched expected %0b, got %0b", $realtime, want, rsp_tdata[0]);
               end
            end
         end
      end
   end

   // Main sequence: reset, directed table, then the randomized phases.
   initial begin
      for (int f = 0; f < NF; f++) begin
         for (int p = 0; p < FB; p++) flt_bytes[f][p] = CHAR_NUL;
      end
      flt_bytes[0][0] = CHAR_STAR;
      flt_bytes[0][1] = CHAR_DOT;
      flt_bytes[0][2] = CHAR_STAR;
      case_blind = 1'b0;
      restart_positions();

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      foreach (DIRECTED_ROWS[i]) begin
         send_item(make_item(DIRECTED_ROWS[i].kind, DIRECTED_ROWS[i].slot,
                             DIRECTED_ROWS[i].offset, DIRECTED_ROWS[i].value,
                             DIRECTED_ROWS[i].last), DIRECTED_ROWS[i].want);
      end

      for (int ph = 0; ph < 4; ph++) begin
         write_ignore_case(CASE_MODE[ph]);
         send_idle  = SEND_IDLE[ph];
         take_stall = TAKE_STALL[ph];
         run_phase(PHASE_ITEMS);
      end

      drain();
      if (mismatches == 0) begin
         $display("[multi_filter_wildcard_match_core] OK");
      end else begin
         $display("[multi_filter_wildcard_match_core] ERROR");
      end
      $finish;
   end

   // Hard stop in case the block hangs or a response never comes.
   initial begin
      #(RUN_LIMIT_NS);
      $display("[multi_filter_wildcard_match_core] ERROR");
      $finish;
   end

endmodule

// ----- multi_filter_wildcard_match_core.f -----
rtl/core/mfwm_pkg.sv
rtl/core/mfwm_cell.sv
rtl/core/multi_filter_wildcard_match_core.sv
tb/sv/tb_top.sv
